// ===== sv/smbc_pkg.sv =====
// smbc_pkg: shared types and constants for the stopwatch menu button controller
// no dependencies; imported by smbc_out_if, the top level and the checker
`default_nettype none

package smbc_pkg;

    localparam int TICK_W     = 32;
    localparam int DEB_W      = 8;
    localparam int LONG_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int PAGE_W     = 2;
    localparam int MIN_W      = 7;
    localparam int SEC_W      = 6;
    localparam int CENTI_W    = 7;

    localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd5;
    localparam logic [LONG_W-1:0] LONG_RESET = 16'd100;

    localparam logic [CENTI_W-1:0] CENTI_LAST = 7'd99;
    localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;
    localparam logic [MIN_W-1:0]   MIN_LAST   = 7'd99;

    localparam logic [PAGE_W-1:0] PAGE_TIME  = 2'd0;
    localparam logic [PAGE_W-1:0] PAGE_WATCH = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'b1;

    typedef enum logic [1:0] {
        WS_STOPPED = 2'd0,
        WS_RUNNING = 2'd1,
        WS_PAUSED  = 2'd2
    } t_watch_state;

endpackage

`default_nettype wire

// ===== sv/smbc_in_if.sv =====
// smbc_in_if: valid/ready channel carrying one tick item with button flags
// depends on nothing; used by the top level input port
`default_nettype none

interface smbc_in_if;
    logic valid;
    logic ready;
    logic next_press;
    logic prev_press;
    logic action_press;
    logic action_held;
    logic prev_held;

    modport source (output valid, output next_press, output prev_press,
                    output action_press, output action_held, output prev_held,
                    input ready);
    modport sink   (input valid, input next_press, input prev_press,
                    input action_press, input action_held, input prev_held,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/smbc_out_if.sv =====
// smbc_out_if: valid/ready channel carrying one result item per tick
// depends on smbc_pkg for field widths
`default_nettype none

interface smbc_out_if;
    import smbc_pkg::*;
    logic               valid;
    logic               ready;
    logic [PAGE_W-1:0]  menu_page;
    logic [1:0]         watch_state;
    logic [MIN_W-1:0]   minutes_out;
    logic [SEC_W-1:0]   seconds_out;
    logic [CENTI_W-1:0] centis_out;
    logic               clock_reset_pulse;

    modport source (output valid, output menu_page, output watch_state,
                    output minutes_out, output seconds_out, output centis_out,
                    output clock_reset_pulse, input ready);
    modport sink   (input valid, input menu_page, input watch_state,
                    input minutes_out, input seconds_out, input centis_out,
                    input clock_reset_pulse, output ready);
endinterface

`default_nettype wire

// ===== sv/stopwatch_menu_button_controller.sv =====
// a result passes through the input register and then the result register
// throughput: one item per cycle while the sink is ready; the single pass from input register to result register
//   updates all state in the cycle the item leaves the input register
// a full result register does not block input while the sink takes it in the same cycle
// reset (synchronous, active low): state cleared, debounce 5, long press 100, no valid items
`default_nettype none

module stopwatch_menu_button_controller #(
    parameter int PAGE_COUNT = 3
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    smbc_in_if.sink                        i_in,
    smbc_out_if.source                     o_out,
    input  wire                            i_cfg_we,
    input  wire [smbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [smbc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import smbc_pkg::*;

    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_COUNT - 1);

    // configuration
    logic [DEB_W-1:0]  r_debounce;
    logic [LONG_W-1:0] r_long_press;

    // input register
    logic r_in_valid;
    logic r_next_press, r_prev_press, r_action_press, r_action_held, r_prev_held;

    // result register
    logic               r_out_valid;
    logic [PAGE_W-1:0]  r_out_page;
    t_watch_state       r_out_ws;
    logic [MIN_W-1:0]   r_out_min;
    logic [SEC_W-1:0]   r_out_sec;
    logic [CENTI_W-1:0] r_out_centi;
    logic               r_out_pulse;

    // controller state
    logic [TICK_W-1:0]  r_tick, n_tick;
    logic [TICK_W-1:0]  r_last_next, n_last_next;
    logic [TICK_W-1:0]  r_last_prev, n_last_prev;
    logic [PAGE_W-1:0]  r_page, n_page;
    t_watch_state       r_run, n_run;
    logic [MIN_W-1:0]   r_min, n_min;
    logic [SEC_W-1:0]   r_sec, n_sec;
    logic [CENTI_W-1:0] r_centi, n_centi;
    logic               r_act_active, n_act_active;
    logic [TICK_W-1:0]  r_act_start, n_act_start;
    logic               r_long_done, n_long_done;
    logic               r_phold_active, n_phold_active;
    logic [TICK_W-1:0]  r_phold_start, n_phold_start;
    logic               r_phold_fired, n_phold_fired;
    logic               n_pulse;

    logic advance;

    // input stage empties when its item moves into a free or draining result register
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid             = r_out_valid;
    assign o_out.menu_page         = r_out_page;
    assign o_out.watch_state       = r_out_ws;
    assign o_out.minutes_out       = r_out_min;
    assign o_out.seconds_out       = r_out_sec;
    assign o_out.centis_out        = r_out_centi;
    assign o_out.clock_reset_pulse = r_out_pulse;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEB_RESET;
            r_long_press <= LONG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_data[DEB_W-1:0];
                CFG_LONG_PRESS: r_long_press <= i_cfg_data[LONG_W-1:0];
                default: ;
            endcase
        end
    end

    // input register: control reset, payload loads on every input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_next_press   <= i_in.next_press;
            r_prev_press   <= i_in.prev_press;
            r_action_press <= i_in.action_press;
            r_action_held  <= i_in.action_held;
            r_prev_held    <= i_in.prev_held;
        end
    end

    // single pass: tick, stopwatch advance, menu, action hold, prev hold
    always_comb begin
        logic [TICK_W-1:0] held_for;
        logic [TICK_W-1:0] phold_for;

        n_tick         = r_tick + TICK_W'(1);
        n_last_next    = r_last_next;
        n_last_prev    = r_last_prev;
        n_page         = r_page;
        n_run          = r_run;
        n_min          = r_min;
        n_sec          = r_sec;
        n_centi        = r_centi;
        n_act_active   = r_act_active;
        n_act_start    = r_act_start;
        n_long_done    = r_long_done;
        n_phold_active = r_phold_active;
        n_phold_start  = r_phold_start;
        n_phold_fired  = r_phold_fired;
        n_pulse        = 1'b0;

        // mm:ss.cc counter, wraps after 99:59.99
        if (r_run == WS_RUNNING) begin
            if (r_centi >= CENTI_LAST) begin
                n_centi = '0;
                if (r_sec >= SEC_LAST) begin
                    n_sec = '0;
                    n_min = (r_min >= MIN_LAST) ? '0 : r_min + MIN_W'(1);
                end else begin
                    n_sec = r_sec + SEC_W'(1);
                end
            end else begin
                n_centi = r_centi + CENTI_W'(1);
            end
        end

        // menu: next first, prev sees the page next left behind
        if (r_next_press && (n_tick - r_last_next) >= TICK_W'(r_debounce)) begin
            n_last_next = n_tick;
            n_page      = (n_page >= PAGE_LAST) ? '0 : n_page + PAGE_W'(1);
        end
        if (r_prev_press && (n_tick - r_last_prev) >= TICK_W'(r_debounce)) begin
            n_last_prev = n_tick;
            n_page      = (n_page == '0) ? PAGE_LAST : n_page - PAGE_W'(1);
        end

        // action button on the stopwatch page: short press toggles, long hold clears
        if (n_page == PAGE_WATCH) begin
            if (r_action_press && r_action_held) begin
                n_act_active = 1'b1;
                n_act_start  = n_tick;
                n_long_done  = 1'b0;
            end
            held_for = n_tick - n_act_start;
            if (n_act_active) begin
                if (r_action_held) begin
                    if (held_for >= TICK_W'(r_long_press) && !n_long_done) begin
                        n_min       = '0;
                        n_sec       = '0;
                        n_centi     = '0;
                        n_run       = WS_STOPPED;
                        n_long_done = 1'b1;
                    end
                end else begin
                    if (held_for < TICK_W'(r_long_press)) begin
                        n_run = (n_run == WS_RUNNING) ? WS_PAUSED : WS_RUNNING;
                    end
                    n_act_active = 1'b0;
                end
            end
        end else begin
            held_for     = '0;
            n_act_active = 1'b0;
        end

        // long prev hold on the time page fires one clock-reset pulse per hold
        if (n_page == PAGE_TIME && r_prev_held) begin
            if (!r_phold_active) begin
                n_phold_active = 1'b1;
                n_phold_start  = n_tick;
                n_phold_fired  = 1'b0;
            end
            phold_for = n_tick - n_phold_start;
            if (phold_for > TICK_W'(r_long_press) && !n_phold_fired) begin
                n_phold_fired = 1'b1;
                n_pulse       = 1'b1;
            end
        end else begin
            phold_for      = '0;
            n_phold_active = 1'b0;
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_tick         <= '0;
            r_last_next    <= '0;
            r_last_prev    <= '0;
            r_page         <= '0;
            r_run          <= WS_STOPPED;
            r_min          <= '0;
            r_sec          <= '0;
            r_centi        <= '0;
            r_act_active   <= 1'b0;
            r_act_start    <= '0;
            r_long_done    <= 1'b0;
            r_phold_active <= 1'b0;
            r_phold_start  <= '0;
            r_phold_fired  <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid    <= 1'b1;
                r_tick         <= n_tick;
                r_last_next    <= n_last_next;
                r_last_prev    <= n_last_prev;
                r_page         <= n_page;
                r_run          <= n_run;
                r_min          <= n_min;
                r_sec          <= n_sec;
                r_centi        <= n_centi;
                r_act_active   <= n_act_active;
                r_act_start    <= n_act_start;
                r_long_done    <= n_long_done;
                r_phold_active <= n_phold_active;
                r_phold_start  <= n_phold_start;
                r_phold_fired  <= n_phold_fired;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out_page  <= n_page;
            r_out_ws    <= n_run;
            r_out_min   <= n_min;
            r_out_sec   <= n_sec;
            r_out_centi <= n_centi;
            r_out_pulse <= n_pulse;
        end
    end

endmodule

`default_nettype wire

// ===== sv/smbc_checker.sv =====
// smbc_checker: port-level checks of the stopwatch menu button controller
// depends on smbc_pkg; bound to stopwatch_menu_button_controller below
`default_nettype none

module smbc_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [smbc_pkg::PAGE_W-1:0]   i_page,
    input wire [1:0]                    i_ws,
    input wire [smbc_pkg::MIN_W-1:0]    i_min,
    input wire [smbc_pkg::SEC_W-1:0]    i_sec,
    input wire [smbc_pkg::CENTI_W-1:0]  i_centi,
    input wire                          i_pulse
);
    import smbc_pkg::*;

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // stalled result payload holds
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_min) && $stable(i_sec) && $stable(i_centi) && $stable(i_page)
            && $stable(i_ws) && $stable(i_pulse))
        else $error("result payload changed while stalled");

    // stopwatch digits stay within 99:59.99
    a_watch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_min <= MIN_LAST) && (i_sec <= SEC_LAST) && (i_centi <= CENTI_LAST))
        else $error("stopwatch value out of range");

    // clock-reset pulse only from the time page
    a_pulse_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_pulse |-> i_page == PAGE_TIME)
        else $error("clock reset pulse off the time page");

endmodule

bind stopwatch_menu_button_controller smbc_checker u_smbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_page      (o_out.menu_page),
    .i_ws        (o_out.watch_state),
    .i_min       (o_out.minutes_out),
    .i_sec       (o_out.seconds_out),
    .i_centi     (o_out.centis_out),
    .i_pulse     (o_out.clock_reset_pulse)
);

`default_nettype wire

// ===== tb/tb_stopwatch_menu_button_controller.sv =====
`timescale 1ns / 1ps
// self-checking testbench for stopwatch_menu_button_controller: directed table and random
// gestures under several thresholds, checked against hand-written expectations or an in-bench model of the block
// depends on smbc_pkg, smbc_in_if and smbc_out_if from the rtl

module tb_stopwatch_menu_button_controller;
    import smbc_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 10;
    localparam int PAGE_COUNT     = 3;
    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int SETTLE_CYCLES  = 6;      // result register sits behind the input register
    localparam int DRAIN_LIMIT    = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int HOLDOFF_AT     = 400;    // result count at which the sink backs off
    localparam int HOLDOFF_CYCLES = 64;
    localparam int RANDOM_ITEMS   = 300;    // per random phase
    localparam int RANDOM_PHASES  = 5;

    localparam logic [PAGE_W-1:0] PAGE_TEMP = 2'd1;
    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_COUNT - 1);

    // threshold settings walked by the random phases: both debounce extremes and a zero hold
    localparam logic [DEB_W-1:0]  PH_DEB  [RANDOM_PHASES] = '{8'd0, 8'd255, 8'd2, 8'd1, 8'd3};
    localparam logic [LONG_W-1:0] PH_LONG [RANDOM_PHASES] = '{16'd1, 16'd7, 16'd0, 16'd3, 16'd12};

    // one tick item, bit order matches the B_* masks below
    typedef struct packed {
        logic next_press;
        logic prev_press;
        logic action_press;
        logic action_held;
        logic prev_held;
    } t_tick;

    // one display result
    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        t_watch_state       state;
        logic [MIN_W-1:0]   minutes;
        logic [SEC_W-1:0]   seconds;
        logic [CENTI_W-1:0] centis;
        logic               pulse;
    } t_disp;

    typedef struct packed {
        logic [4:0] stim;
        logic       typed;  // want holds a hand-written expectation
        t_disp      want;
    } t_dir_row;

    localparam logic [4:0] B_NONE   = 5'b00000;
    localparam logic [4:0] B_NEXT   = 5'b10000;
    localparam logic [4:0] B_PREV   = 5'b01000;
    localparam logic [4:0] B_APRESS = 5'b00100;
    localparam logic [4:0] B_AHELD  = 5'b00010;
    localparam logic [4:0] B_PHELD  = 5'b00001;

    localparam t_disp WANT_TIME = '{PAGE_TIME, WS_STOPPED, '0, '0, '0, 1'b0};
    localparam t_disp WANT_TEMP = '{PAGE_TEMP, WS_STOPPED, '0, '0, '0, 1'b0};

    localparam int DIR_ROWS = 25;
    // reset thresholds apply here: debounce 5, long press 100
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{B_NONE,                    1'b1, WANT_TIME},  // quiet first tick after reset
        '{B_NEXT,                    1'b1, WANT_TIME},  // too early after reset, ignored
        '{B_PREV,                    1'b1, WANT_TIME},  // too early after reset, ignored
        '{B_PHELD,                   1'b1, WANT_TIME},  // prev hold starts on time page
        '{B_NEXT,                    1'b1, WANT_TEMP},  // first accepted next
        '{B_APRESS | B_AHELD,        1'b0, '0},         // action off the stopwatch page
        '{B_PREV,                    1'b0, '0},         // back to time page
        '{B_PREV,                    1'b0, '0},         // inside debounce window
        '{B_NONE,                    1'b0, '0},
        '{B_NONE,                    1'b0, '0},
        '{B_NONE,                    1'b0, '0},
        '{B_NONE,                    1'b0, '0},
        '{B_NEXT | B_PREV,           1'b0, '0},         // both on one tick, next first
        '{B_NONE,                    1'b0, '0},
        '{B_NONE,                    1'b0, '0},
        '{B_NONE,                    1'b0, '0},
        '{B_NONE,                    1'b0, '0},
        '{B_PREV,                    1'b0, '0},         // wraps back to stopwatch page
        '{B_APRESS,                  1'b0, '0},         // edge without the level, ignored
        '{B_APRESS | B_AHELD,        1'b0, '0},         // short press starts
        '{B_NONE,                    1'b0, '0},         // release: start
        '{B_NONE,                    1'b0, '0},         // counting
        '{B_APRESS | B_AHELD,        1'b0, '0},
        '{B_NONE,                    1'b0, '0},         // release: pause
        '{B_NEXT | B_PREV | B_APRESS | B_AHELD | B_PHELD, 1'b0, '0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    smbc_in_if  in_if ();
    smbc_out_if out_if ();

    stopwatch_menu_button_controller #(
        .PAGE_COUNT (PAGE_COUNT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // model of the controller, starting from its reset state
    logic [DEB_W-1:0]   deb_gap     = DEB_RESET;
    logic [LONG_W-1:0]  hold_len    = LONG_RESET;
    logic [TICK_W-1:0]  tick_now    = '0;
    logic [TICK_W-1:0]  next_at     = '0;
    logic [TICK_W-1:0]  prev_at     = '0;
    logic [PAGE_W-1:0]  page_now    = PAGE_TIME;
    t_watch_state       watch_run   = WS_STOPPED;
    logic [MIN_W-1:0]   sw_min      = '0;
    logic [SEC_W-1:0]   sw_sec      = '0;
    logic [CENTI_W-1:0] sw_cs       = '0;
    logic               tap_live    = 1'b0;
    logic [TICK_W-1:0]  tap_from    = '0;
    logic               tap_cleared = 1'b0;
    logic               phold_live  = 1'b0;
    logic [TICK_W-1:0]  phold_from  = '0;
    logic               phold_fired = 1'b0;

    t_disp       pending_disp [$];   // expected displays, oldest first
    int unsigned fail_count  = 0;
    int unsigned disp_seen   = 0;
    int unsigned ticks_sent  = 0;
    int unsigned cycle_count = 0;
    bit          src_busy    = 1'b1;
    bit          snk_busy    = 1'b1;

    function automatic int unsigned pick_wait(input bit busy);
        return busy ? $urandom_range(0, 4) : 0;
    endfunction

    function automatic string show(input t_disp d);
        return $sformatf("page %0d state %0d %0d:%0d.%0d pulse %0b",
                         d.page, d.state, d.minutes, d.seconds, d.centis, d.pulse);
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%s", what);
    endtask

    // one tick of the controller: counters, menu, action button, prev hold
    task automatic predict_display(input t_tick t, output t_disp d);
        logic [TICK_W-1:0] held_for;
        logic              pulse;
        pulse = 1'b0;
        tick_now = tick_now + 1'b1;

        if (watch_run == WS_RUNNING) begin
            if (sw_cs == CENTI_LAST) begin
                sw_cs = '0;
                if (sw_sec == SEC_LAST) begin
                    sw_sec = '0;
                    sw_min = (sw_min == MIN_LAST) ? '0 : sw_min + 1'b1;
                end else begin
                    sw_sec = sw_sec + 1'b1;
                end
            end else begin
                sw_cs = sw_cs + 1'b1;
            end
        end

        // next is handled before prev, differences wrap at 32 bits
        if (t.next_press && TICK_W'(tick_now - next_at) >= TICK_W'(deb_gap)) begin
            next_at  = tick_now;
            page_now = (page_now == PAGE_LAST) ? '0 : page_now + 1'b1;
        end
        if (t.prev_press && TICK_W'(tick_now - prev_at) >= TICK_W'(deb_gap)) begin
            prev_at  = tick_now;
            page_now = (page_now == '0) ? PAGE_LAST : page_now - 1'b1;
        end

        if (page_now == PAGE_WATCH) begin
            if (t.action_press && t.action_held) begin
                tap_live    = 1'b1;
                tap_from    = tick_now;
                tap_cleared = 1'b0;
            end
            if (tap_live) begin
                held_for = tick_now - tap_from;
                if (t.action_held) begin
                    // long hold clears once per hold
                    if (held_for >= TICK_W'(hold_len) && !tap_cleared) begin
                        sw_min      = '0;
                        sw_sec      = '0;
                        sw_cs       = '0;
                        watch_run   = WS_STOPPED;
                        tap_cleared = 1'b1;
                    end
                end else begin
                    if (held_for < TICK_W'(hold_len))
                        watch_run = (watch_run == WS_RUNNING) ? WS_PAUSED : WS_RUNNING;
                    tap_live = 1'b0;
                end
            end
        end else begin
            tap_live = 1'b0;
        end

        if (page_now == PAGE_TIME && t.prev_held) begin
            if (!phold_live) begin
                phold_live  = 1'b1;
                phold_from  = tick_now;
                phold_fired = 1'b0;
            end
            if (TICK_W'(tick_now - phold_from) > TICK_W'(hold_len) && !phold_fired) begin
                phold_fired = 1'b1;
                pulse       = 1'b1;
            end
        end else begin
            phold_live = 1'b0;
        end

        d = '{page_now, watch_run, sw_min, sw_sec, sw_cs, pulse};
    endtask

    // offers one tick after a random gap and files its expected display on transfer
    task automatic push_tick(input t_tick t, input logic typed = 1'b0,
                             input t_disp want = '0);
        int unsigned gap;
        t_disp       calc;
        if ($urandom_range(0, 31) == 0)
            src_busy = !src_busy;
        gap = pick_wait(src_busy);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.next_press   <= t.next_press;
        in_if.prev_press   <= t.prev_press;
        in_if.action_press <= t.action_press;
        in_if.action_held  <= t.action_held;
        in_if.prev_held    <= t.prev_held;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predict_display(t, calc);
        pending_disp.push_back(typed ? want : calc);
        ticks_sent++;
    endtask

    // thresholds change only with the block empty
    task automatic set_thresholds(input logic [DEB_W-1:0] deb,
                                  input logic [LONG_W-1:0] hold);
        in_if.valid <= 1'b0;
        while (pending_disp.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DEBOUNCE;
        i_cfg_data <= CFG_DATA_W'(deb);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LONG_PRESS;
        i_cfg_data <= CFG_DATA_W'(hold);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        deb_gap  = deb;
        hold_len = hold;
    endtask

    // random button gestures: mostly whole presses and holds, some raw noise
    task automatic run_random(input int unsigned n_items);
        int unsigned target;
        int unsigned len;
        t_tick       t;
        target = ticks_sent + n_items;
        while (ticks_sent < target) begin
            t = '0;
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 6)) push_tick(t);
                end
                2, 3: begin
                    t.next_press = 1'b1;
                    push_tick(t);
                end
                4: begin
                    t.prev_press = 1'b1;
                    t.prev_held  = 1'($urandom_range(0, 1));
                    push_tick(t);
                end
                5, 6: begin
                    // press, hold, let go; lengths straddle the long threshold
                    len = $urandom_range(0, 2 * int'(hold_len) + 2);
                    t.action_press = 1'b1;
                    t.action_held  = 1'b1;
                    push_tick(t);
                    t.action_press = 1'b0;
                    repeat (len) begin
                        // now and then page away mid hold
                        t.next_press = ($urandom_range(0, 7) == 0);
                        push_tick(t);
                    end
                    t = '0;
                    push_tick(t);
                end
                7: begin
                    len = $urandom_range(1, int'(hold_len) + 3);
                    t.prev_held = 1'b1;
                    repeat (len) push_tick(t);
                    t.prev_held = 1'b0;
                    push_tick(t);
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        push_tick(t_tick'(5'($urandom_range(0, 31))));
                end
            endcase
        end
    endtask

    // result side: random stalls, one long hold-off, in-order compare
    initial begin : result_sink
        int unsigned stall;
        t_disp       got;
        t_disp       want;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0)
                snk_busy = !snk_busy;
            // the long hold-off lets the input side back up and stall
            stall = (disp_seen == HOLDOFF_AT) ? HOLDOFF_CYCLES : pick_wait(snk_busy);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            disp_seen++;
            got.page    = out_if.menu_page;
            got.state   = t_watch_state'(out_if.watch_state);
            got.minutes = out_if.minutes_out;
            got.seconds = out_if.seconds_out;
            got.centis  = out_if.centis_out;
            got.pulse   = out_if.clock_reset_pulse;
            if (pending_disp.size() == 0) begin
                note_failure({"unexpected result: ", show(got)});
            end else begin
                want = pending_disp.pop_front();
                if (got.page !== want.page || got.state !== want.state ||
                    got.minutes !== want.minutes || got.seconds !== want.seconds ||
                    got.centis !== want.centis || got.pulse !== want.pulse)
                    note_failure($sformatf("mismatch at result %0d: want %s, got %s",
                                           disp_seen, show(want), show(got)));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned row;
        int unsigned ph;
        int unsigned w;

        in_if.valid        <= 1'b0;
        in_if.next_press   <= 1'b0;
        in_if.prev_press   <= 1'b0;
        in_if.action_press <= 1'b0;
        in_if.action_held  <= 1'b0;
        in_if.prev_held    <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_DEBOUNCE;
        i_cfg_data         <= '0;
        i_rst_n            <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under reset thresholds
        for (row = 0; row < DIR_ROWS; row++)
            push_tick(t_tick'(DIR_TABLE[row].stim), DIR_TABLE[row].typed, DIR_TABLE[row].want);

        // random gestures under several threshold settings
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_thresholds(PH_DEB[ph], PH_LONG[ph]);
            run_random(RANDOM_ITEMS);
        end

        // let the last results out
        in_if.valid <= 1'b0;
        for (w = 0; w < DRAIN_LIMIT && pending_disp.size() != 0; w++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_disp.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_disp.size()));

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== stopwatch_menu_button_controller.f =====
sv/smbc_pkg.sv
sv/smbc_in_if.sv
sv/smbc_out_if.sv
sv/stopwatch_menu_button_controller.sv
sv/smbc_checker.sv
tb/tb_stopwatch_menu_button_controller.sv
